// ===== rtl/ber_pkg.sv =====
// Shared types and constants of the binaural ear renderer.
`default_nettype none
package ber_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int DELAY_W    = 24;
    localparam int LOAD_W     = 22;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // digit-serial multiplier: 18-bit multiplicand, 20-bit multiplier, radix 16
    localparam int MCAND_W    = 18;
    localparam int MPLIER_W   = 20;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = MPLIER_W / DIGIT_W;
    localparam int CNT_W      = $clog2(NUM_DIGITS);
    localparam int PROD_W     = 40;

    // largest read delay, 62.0 samples in Q6.16
    localparam logic [LOAD_W-1:0] MAX_DELAY = LOAD_W'(62 * 65536);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT_ZERO,
        CFG_LEFT_PAST,
        CFG_RIGHT_ZERO,
        CFG_RIGHT_PAST,
        CFG_POLE,
        CFG_LEFT_STEP,
        CFG_RIGHT_STEP
    } cfg_index_t;

    typedef enum logic {
        OP_PROCESS,
        OP_LOAD
    } op_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_MSTART,
        S_MWAIT,
        S_FILT,
        S_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_INTERP,
        PH_B0,
        PH_B1,
        PH_A1
    } phase_t;

    typedef struct packed {
        logic                        start;
        logic signed [MCAND_W-1:0]   mcand;
        logic signed [MPLIER_W-1:0]  mplier;
    } mult_req_t;

endpackage
`default_nettype wire

// ===== rtl/ber_ring.sv =====
// Sample delay ring: one write port, two registered read ports, valid bit per entry.
`default_nettype none
module ber_ring #(
    parameter int DEPTH = 64
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         we,
    input  logic [$clog2(DEPTH)-1:0]     waddr,
    input  logic signed [15:0]           wdata,
    input  logic                         re,
    input  logic [$clog2(DEPTH)-1:0]     raddr_a,
    input  logic [$clog2(DEPTH)-1:0]     raddr_b,
    output logic signed [15:0]           rdata_a,
    output logic signed [15:0]           rdata_b
);
    import ber_pkg::*;

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]           valid_reg;
    logic signed [SAMPLE_W-1:0] rdata_a_reg;
    logic signed [SAMPLE_W-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // entries never written read as zero
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= valid_reg[raddr_a] ? mem[raddr_a] : '0;
            rdata_b_reg <= valid_reg[raddr_b] ? mem[raddr_b] : '0;
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

// ===== rtl/ber_digit_mult.sv =====
// Signed digit-serial multiplier, four multiplier bits per cycle, most significant first.
`default_nettype none
module ber_digit_mult (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ber_pkg::mult_req_t                   req,
    output logic                                 done,
    output logic signed [ber_pkg::PROD_W-1:0]    product
);
    import ber_pkg::*;

    logic signed [MCAND_W-1:0]   mcand_reg;
    logic [MPLIER_W-1:0]         mplier_reg;
    logic signed [PROD_W-1:0]    acc_reg;
    logic signed [PROD_W-1:0]    acc_next;
    logic [CNT_W-1:0]            cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;
    logic                        last_digit;
    logic [DIGIT_W-1:0]          digit;
    logic signed [DIGIT_W:0]     digit_s;
    logic signed [MCAND_W+DIGIT_W:0] partial;
    logic signed [PROD_W-1:0]    partial_ext;

    assign last_digit = (cnt_reg == CNT_W'(NUM_DIGITS - 1));
    assign digit      = mplier_reg[MPLIER_W-1 -: DIGIT_W];

    always_comb begin
        // top digit carries the sign, the rest are plain magnitudes
        if (cnt_reg == '0) begin
            digit_s = $signed({digit[DIGIT_W-1], digit});
        end else begin
            digit_s = $signed({1'b0, digit});
        end
        partial     = mcand_reg * digit_s;
        partial_ext = PROD_W'(partial);
        acc_next    = (acc_reg <<< DIGIT_W) + partial_ext;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && last_digit;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_digit) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (req.start) begin
            mcand_reg  <= req.mcand;
            mplier_reg <= req.mplier;
            acc_reg    <= '0;
        end else if (busy_reg) begin
            mplier_reg <= mplier_reg << DIGIT_W;
            acc_reg    <= acc_next;
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/binaural_ear_renderer.sv =====
// Process item: the next item is taken only once the result has gone to the output register;
// the work is eight digit-serial multiplies (start, five digits, hand-off), a ring read
// and a filter update per ear, and the output step, which waits while the output register is full.
// Load item: the next item is taken in the following cycle. A finished result
// waits in the output register while the next item is accepted.
// Synchronous active-low reset: ring, pointer, delays, filter history clear, b0 = 1.0, rest 0.
`default_nettype none
module binaural_ear_renderer #(
    parameter int RING_DEPTH = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    // tuser: operation
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [0:0]  s_tuser,
    // tdata: mono_sample[15:0], left_delay_load[37:16], right_delay_load[59:38], zero pad
    input  logic [63:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // tdata: left_sample[15:0], right_sample[31:16]
    output logic [31:0] m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [ber_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ber_pkg::CFG_DATA_W-1:0] cfg_data
);
    import ber_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);

    state_t state_reg, state_next;
    phase_t phase_reg, phase_next;
    logic   ear_reg, ear_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic signed [DELAY_W-1:0]  left_delay_reg, left_delay_next;
    logic signed [DELAY_W-1:0]  right_delay_reg, right_delay_next;
    logic signed [SAMPLE_W-1:0] left_in_reg, left_in_next;
    logic signed [SAMPLE_W-1:0] left_out_reg, left_out_next;
    logic signed [SAMPLE_W-1:0] right_in_reg, right_in_next;
    logic signed [SAMPLE_W-1:0] right_out_reg, right_out_next;
    logic signed [SAMPLE_W-1:0] filt_in_reg, filt_in_next;
    logic signed [PROD_W-1:0]   sum_reg, sum_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic signed [COEF_W-1:0]  left_zero_reg, left_past_reg;
    logic signed [COEF_W-1:0]  right_zero_reg, right_past_reg;
    logic signed [COEF_W-1:0]  pole_reg;
    logic signed [DELAY_W-1:0] left_step_reg, right_step_reg;

    logic in_accept;
    logic out_free;
    op_t  op;
    logic signed [SAMPLE_W-1:0] mono;
    logic [LOAD_W-1:0]          left_load, right_load;
    logic signed [DELAY_W:0]    left_sum25, right_sum25;
    logic signed [DELAY_W-1:0]  left_sat, right_sat;

    logic signed [DELAY_W-1:0]  cur_delay;
    logic [LOAD_W-1:0]          rd;
    logic [5:0]                 whole;
    logic [15:0]                part;
    logic [AW:0]                ia_wide, ib_wide;
    logic [AW-1:0]              ia, ib;
    logic signed [SAMPLE_W-1:0] ring_a, ring_b;
    logic                       ring_we, ring_re;
    logic signed [SAMPLE_W:0]   diff;

    logic signed [COEF_W-1:0]   cur_b0, cur_b1;
    logic signed [SAMPLE_W-1:0] cur_last_in, cur_last_out;
    mult_req_t                  mreq;
    logic                       mdone;
    logic signed [PROD_W-1:0]   mprod;

    logic signed [PROD_W-1:0]   interp_rnd;
    logic signed [17:0]         interp_wide;
    logic signed [SAMPLE_W-1:0] interp_in;
    logic signed [PROD_W-1:0]   filt_q;
    logic signed [SAMPLE_W-1:0] filt_out;

    function automatic logic signed [DELAY_W-1:0] sat_delay(logic signed [DELAY_W:0] v);
        logic signed [DELAY_W-1:0] r;
        if (v[DELAY_W] != v[DELAY_W-1]) begin
            r = v[DELAY_W] ? {1'b1, {(DELAY_W-1){1'b0}}} : {1'b0, {(DELAY_W-1){1'b1}}};
        end else begin
            r = v[DELAY_W-1:0];
        end
        return r;
    endfunction

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign op         = op_t'(s_tuser[0]);
    assign mono       = $signed(s_tdata[15:0]);
    assign left_load  = s_tdata[37:16];
    assign right_load = s_tdata[59:38];

    assign left_sum25  = (DELAY_W+1)'(left_delay_reg) + (DELAY_W+1)'(left_step_reg);
    assign right_sum25 = (DELAY_W+1)'(right_delay_reg) + (DELAY_W+1)'(right_step_reg);
    assign left_sat    = sat_delay(left_sum25);
    assign right_sat   = sat_delay(right_sum25);

    // read taps of the current ear
    always_comb begin
        cur_delay = ear_reg ? right_delay_reg : left_delay_reg;
        if (cur_delay[DELAY_W-1]) begin
            rd = '0;
        end else if (cur_delay[LOAD_W:0] > {1'b0, MAX_DELAY}) begin
            rd = MAX_DELAY;
        end else begin
            rd = cur_delay[LOAD_W-1:0];
        end
        whole   = rd[LOAD_W-1:16];
        part    = rd[15:0];
        ia_wide = (AW+1)'(ptr_reg) - (AW+1)'(whole);
        ib_wide = (AW+1)'(ptr_reg) - (AW+1)'(whole) - 1'b1;
        if (ia_wide[AW]) begin
            ia_wide = ia_wide + (AW+1)'(RING_DEPTH);
        end
        if (ib_wide[AW]) begin
            ib_wide = ib_wide + (AW+1)'(RING_DEPTH);
        end
        ia = ia_wide[AW-1:0];
        ib = ib_wide[AW-1:0];
    end

    assign ring_we = in_accept && (op == OP_PROCESS);
    assign ring_re = (state_reg == S_ADDR);

    ber_ring #(
        .DEPTH(RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (ring_we),
        .waddr   (ptr_reg),
        .wdata   (mono),
        .re      (ring_re),
        .raddr_a (ia),
        .raddr_b (ib),
        .rdata_a (ring_a),
        .rdata_b (ring_b)
    );

    assign diff         = (SAMPLE_W+1)'(ring_b) - (SAMPLE_W+1)'(ring_a);
    assign cur_b0       = ear_reg ? right_zero_reg : left_zero_reg;
    assign cur_b1       = ear_reg ? right_past_reg : left_past_reg;
    assign cur_last_in  = ear_reg ? right_in_reg : left_in_reg;
    assign cur_last_out = ear_reg ? right_out_reg : left_out_reg;

    always_comb begin
        mreq.start  = (state_reg == S_MSTART);
        unique case (phase_reg)
            PH_INTERP: begin
                mreq.mcand  = MCAND_W'(diff);
                mreq.mplier = $signed(MPLIER_W'(part));
            end
            PH_B0: begin
                mreq.mcand  = cur_b0;
                mreq.mplier = MPLIER_W'(filt_in_reg);
            end
            PH_B1: begin
                mreq.mcand  = cur_b1;
                mreq.mplier = MPLIER_W'(cur_last_in);
            end
            PH_A1: begin
                mreq.mcand  = pole_reg;
                mreq.mplier = MPLIER_W'(cur_last_out);
            end
            default: begin
                mreq.mcand  = '0;
                mreq.mplier = '0;
            end
        endcase
    end

    ber_digit_mult u_mult (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq),
        .done    (mdone),
        .product (mprod)
    );

    // interpolated sample and filter output rounding
    always_comb begin
        interp_rnd  = (mprod + PROD_W'(32768)) >>> 16;
        interp_wide = 18'(ring_a) + $signed(interp_rnd[17:0]);
        if (interp_wide > 18'sd32767) begin
            interp_in = 16'sh7fff;
        end else if (interp_wide < -18'sd32768) begin
            interp_in = 16'sh8000;
        end else begin
            interp_in = interp_wide[SAMPLE_W-1:0];
        end
        filt_q = (sum_reg + PROD_W'(8192)) >>> 14;
        if (filt_q > PROD_W'(32767)) begin
            filt_out = 16'sh7fff;
        end else if (filt_q < -PROD_W'(32768)) begin
            filt_out = 16'sh8000;
        end else begin
            filt_out = filt_q[SAMPLE_W-1:0];
        end
    end

    always_comb begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        ear_next         = ear_reg;
        ptr_next         = ptr_reg;
        left_delay_next  = left_delay_reg;
        right_delay_next = right_delay_reg;
        left_in_next     = left_in_reg;
        left_out_next    = left_out_reg;
        right_in_next    = right_in_reg;
        right_out_next   = right_out_reg;
        filt_in_next     = filt_in_reg;
        sum_next         = sum_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    if (op == OP_LOAD) begin
                        left_delay_next  = $signed(DELAY_W'(left_load));
                        right_delay_next = $signed(DELAY_W'(right_load));
                    end else begin
                        left_delay_next  = left_sat;
                        right_delay_next = right_sat;
                        ear_next         = 1'b0;
                        phase_next       = PH_INTERP;
                        state_next       = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                state_next = S_MSTART;
            end
            S_MSTART: begin
                state_next = S_MWAIT;
            end
            S_MWAIT: begin
                if (mdone) begin
                    unique case (phase_reg)
                        PH_INTERP: begin
                            filt_in_next = interp_in;
                            phase_next   = PH_B0;
                            state_next   = S_MSTART;
                        end
                        PH_B0: begin
                            sum_next   = mprod;
                            phase_next = PH_B1;
                            state_next = S_MSTART;
                        end
                        PH_B1: begin
                            sum_next   = sum_reg + mprod;
                            phase_next = PH_A1;
                            state_next = S_MSTART;
                        end
                        PH_A1: begin
                            sum_next   = sum_reg - mprod;
                            phase_next = PH_INTERP;
                            state_next = S_FILT;
                        end
                        default: begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_FILT: begin
                if (!ear_reg) begin
                    left_in_next  = filt_in_reg;
                    left_out_next = filt_out;
                    ear_next      = 1'b1;
                    state_next    = S_ADDR;
                end else begin
                    right_in_next  = filt_in_reg;
                    right_out_next = filt_out;
                    state_next     = S_DONE;
                end
            end
            S_DONE: begin
                // hold until the output register is free
                if (out_free) begin
                    m_data_next  = {right_out_reg, left_out_reg};
                    m_valid_next = 1'b1;
                    if (ptr_reg == AW'(RING_DEPTH - 1)) begin
                        ptr_next = '0;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                    end
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            phase_reg       <= PH_INTERP;
            ear_reg         <= 1'b0;
            ptr_reg         <= '0;
            left_delay_reg  <= '0;
            right_delay_reg <= '0;
            left_in_reg     <= '0;
            left_out_reg    <= '0;
            right_in_reg    <= '0;
            right_out_reg   <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            ear_reg         <= ear_next;
            ptr_reg         <= ptr_next;
            left_delay_reg  <= left_delay_next;
            right_delay_reg <= right_delay_next;
            left_in_reg     <= left_in_next;
            left_out_reg    <= left_out_next;
            right_in_reg    <= right_in_next;
            right_out_reg   <= right_out_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        filt_in_reg <= filt_in_next;
        sum_reg     <= sum_next;
        m_data_reg  <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_zero_reg  <= COEF_W'(16384);
            left_past_reg  <= '0;
            right_zero_reg <= COEF_W'(16384);
            right_past_reg <= '0;
            pole_reg       <= '0;
            left_step_reg  <= '0;
            right_step_reg <= '0;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                CFG_LEFT_ZERO:  left_zero_reg  <= cfg_data[COEF_W-1:0];
                CFG_LEFT_PAST:  left_past_reg  <= cfg_data[COEF_W-1:0];
                CFG_RIGHT_ZERO: right_zero_reg <= cfg_data[COEF_W-1:0];
                CFG_RIGHT_PAST: right_past_reg <= cfg_data[COEF_W-1:0];
                CFG_POLE:       pole_reg       <= cfg_data[COEF_W-1:0];
                CFG_LEFT_STEP:  left_step_reg  <= cfg_data[DELAY_W-1:0];
                CFG_RIGHT_STEP: right_step_reg <= cfg_data[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

endmodule
`default_nettype wire
